FILE: rtl/crtc_pkg.sv
// ----------------------------------------------------------------------------
// crtc_pkg
// Shared types and constants for the CRT controller register file.
// ----------------------------------------------------------------------------
`default_nettype none

package crtc_pkg;

   typedef enum logic [1:0] {
      ACT_WRITE_INDEX = 2'd0,
      ACT_READ_INDEX  = 2'd1,
      ACT_WRITE_DATA  = 2'd2,
      ACT_READ_DATA   = 2'd3
   } action_type;

   localparam logic [7:0] IDX_H_TOTAL      = 8'h00;
   localparam logic [7:0] IDX_H_DISPLAYED  = 8'h01;
   localparam logic [7:0] IDX_H_SYNC_POS   = 8'h02;
   localparam logic [7:0] IDX_SYNC_WIDTH   = 8'h03;
   localparam logic [7:0] IDX_V_TOTAL      = 8'h04;
   localparam logic [7:0] IDX_V_ADJUST     = 8'h05;
   localparam logic [7:0] IDX_V_DISPLAYED  = 8'h06;
   localparam logic [7:0] IDX_V_SYNC_POS   = 8'h07;
   localparam logic [7:0] IDX_MAX_SCAN     = 8'h09;
   localparam logic [7:0] IDX_CURSOR_START = 8'h0A;
   localparam logic [7:0] IDX_CURSOR_END   = 8'h0B;
   localparam logic [7:0] IDX_START_HI     = 8'h0C;
   localparam logic [7:0] IDX_START_LO     = 8'h0D;
   localparam logic [7:0] IDX_CURSOR_HI    = 8'h0E;
   localparam logic [7:0] IDX_CURSOR_LO    = 8'h0F;
   localparam logic [7:0] IDX_PEN_HI       = 8'h10;
   localparam logic [7:0] IDX_PEN_LO       = 8'h11;

   localparam logic [7:0] BAD_INDEX_DATA   = 8'hFF;
   localparam logic [4:0] V_SYNC_FIXED     = 5'd16;
   localparam logic [1:0] CURSOR_OFF_CODE  = 2'b01;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 56;

   // Packed so that the last field sits in the lowest bits.
   typedef struct packed {
      logic [2:0]  pad;
      logic [15:0] cursor_address_out;
      logic [15:0] display_start_out;
      logic [4:0]  cursor_last_line;
      logic [4:0]  cursor_first_line;
      logic        cursor_enabled;
      logic        illegal_index;
      logic        resize_request;
      logic [7:0]  read_data;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/crtc_reg_bank.sv
// ----------------------------------------------------------------------------
// crtc_reg_bank
// Indexed register bank: decodes one access, updates the registers and
// forms the result of that access.
// ----------------------------------------------------------------------------
`default_nettype none

module crtc_reg_bank (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_en,
   input  wire crtc_pkg::action_type action,
   input  wire logic [7:0]       bus_data,
   input  wire logic             variant_mode,
   output crtc_pkg::rsp_type     result
);
   import crtc_pkg::*;

   logic [7:0]  index_ff,       index_in;
   logic [7:0]  h_total_ff,     h_total_in;
   logic [7:0]  h_disp_ff,      h_disp_in;
   logic [7:0]  h_sync_pos_ff,  h_sync_pos_in;
   logic [3:0]  h_sync_w_ff,    h_sync_w_in;
   logic [4:0]  v_sync_w_ff,    v_sync_w_in;
   logic [7:0]  v_total_ff,     v_total_in;
   logic [7:0]  v_adjust_ff,    v_adjust_in;
   logic [7:0]  v_disp_ff,      v_disp_in;
   logic [7:0]  v_sync_pos_ff,  v_sync_pos_in;
   logic [4:0]  max_scan_ff,    max_scan_in;
   logic [5:0]  cur_start_ff,   cur_start_in;
   logic [4:0]  cur_end_ff,     cur_end_in;
   logic [15:0] start_addr_ff,  start_addr_in;
   logic [15:0] cur_loc_ff,     cur_loc_in;
   logic [13:0] pen_ff,         pen_in;
   logic        cur_vis_ff,     cur_vis_in;

   logic [7:0]  rd_data;
   logic        resize;
   logic        bad;

   always_comb begin
      index_in      = index_ff;
      h_total_in    = h_total_ff;
      h_disp_in     = h_disp_ff;
      h_sync_pos_in = h_sync_pos_ff;
      h_sync_w_in   = h_sync_w_ff;
      v_sync_w_in   = v_sync_w_ff;
      v_total_in    = v_total_ff;
      v_adjust_in   = v_adjust_ff;
      v_disp_in     = v_disp_ff;
      v_sync_pos_in = v_sync_pos_ff;
      max_scan_in   = max_scan_ff;
      cur_start_in  = cur_start_ff;
      cur_end_in    = cur_end_ff;
      start_addr_in = start_addr_ff;
      cur_loc_in    = cur_loc_ff;
      pen_in        = pen_ff;
      cur_vis_in    = cur_vis_ff;
      rd_data       = 8'h00;
      resize        = 1'b0;
      bad           = 1'b0;

      unique case (action)
         ACT_WRITE_INDEX: begin
            index_in = bus_data;
         end
         ACT_READ_INDEX: begin
            rd_data = index_ff;
         end
         ACT_WRITE_DATA: begin
            unique case (index_ff)
               IDX_H_TOTAL: begin
                  h_total_in = bus_data;
                  resize     = (h_total_ff != bus_data);
               end
               IDX_H_DISPLAYED: begin
                  h_disp_in = bus_data;
                  resize    = (h_disp_ff != bus_data);
               end
               IDX_H_SYNC_POS: h_sync_pos_in = bus_data;
               IDX_SYNC_WIDTH: begin
                  h_sync_w_in = bus_data[3:0];
                  v_sync_w_in = variant_mode ? {1'b0, bus_data[7:4]} : V_SYNC_FIXED;
               end
               IDX_V_TOTAL: begin
                  v_total_in = bus_data;
                  resize     = (v_total_ff != bus_data);
               end
               IDX_V_ADJUST: begin
                  v_adjust_in = bus_data;
                  resize      = (v_adjust_ff != bus_data);
               end
               IDX_V_DISPLAYED: begin
                  v_disp_in = bus_data;
                  resize    = (v_disp_ff != bus_data);
               end
               IDX_V_SYNC_POS: v_sync_pos_in = bus_data;
               IDX_MAX_SCAN: begin
                  max_scan_in = bus_data[4:0];
                  resize      = (max_scan_ff != bus_data[4:0]);
               end
               IDX_CURSOR_START: begin
                  cur_start_in = bus_data[5:0];
                  cur_vis_in   = (bus_data[6:5] != CURSOR_OFF_CODE);
               end
               IDX_CURSOR_END:   cur_end_in          = bus_data[4:0];
               IDX_START_HI:     start_addr_in[15:8] = bus_data;
               IDX_START_LO:     start_addr_in[7:0]  = bus_data;
               IDX_CURSOR_HI:    cur_loc_in[15:8]    = bus_data;
               IDX_CURSOR_LO:    cur_loc_in[7:0]     = bus_data;
               IDX_PEN_HI:       pen_in[13:8]        = bus_data[5:0];
               IDX_PEN_LO:       pen_in[7:0]         = bus_data;
               default:          bad                 = 1'b1;
            endcase
         end
         ACT_READ_DATA: begin
            unique case (index_ff)
               IDX_H_TOTAL:      rd_data = h_total_ff;
               IDX_H_DISPLAYED:  rd_data = h_disp_ff;
               IDX_H_SYNC_POS:   rd_data = h_sync_pos_ff;
               IDX_SYNC_WIDTH:
                  rd_data = variant_mode ? {v_sync_w_ff[3:0], h_sync_w_ff}
                                         : {4'h0, h_sync_w_ff};
               IDX_V_TOTAL:      rd_data = v_total_ff;
               IDX_V_ADJUST:     rd_data = v_adjust_ff;
               IDX_V_DISPLAYED:  rd_data = v_disp_ff;
               IDX_V_SYNC_POS:   rd_data = v_sync_pos_ff;
               IDX_MAX_SCAN:     rd_data = {3'b000, max_scan_ff};
               IDX_CURSOR_START: rd_data = {2'b00, cur_start_ff};
               IDX_CURSOR_END:   rd_data = {3'b000, cur_end_ff};
               IDX_START_HI:     rd_data = start_addr_ff[15:8];
               IDX_START_LO:     rd_data = start_addr_ff[7:0];
               IDX_CURSOR_HI:    rd_data = cur_loc_ff[15:8];
               IDX_CURSOR_LO:    rd_data = cur_loc_ff[7:0];
               IDX_PEN_HI:       rd_data = {2'b00, pen_ff[13:8]};
               IDX_PEN_LO:       rd_data = pen_ff[7:0];
               default: begin
                  rd_data = BAD_INDEX_DATA;
                  bad     = 1'b1;
               end
            endcase
         end
      endcase
   end

   always_comb begin
      result                    = '0;
      result.read_data          = rd_data;
      result.resize_request     = resize;
      result.illegal_index      = bad;
      result.cursor_enabled     = cur_vis_in;
      result.cursor_first_line  = cur_start_in[4:0];
      result.cursor_last_line   = cur_end_in;
      result.display_start_out  = start_addr_in;
      result.cursor_address_out = cur_loc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff      <= '0;
         h_total_ff    <= '0;
         h_disp_ff     <= '0;
         h_sync_pos_ff <= '0;
         h_sync_w_ff   <= '0;
         v_sync_w_ff   <= '0;
         v_total_ff    <= '0;
         v_adjust_ff   <= '0;
         v_disp_ff     <= '0;
         v_sync_pos_ff <= '0;
         max_scan_ff   <= '0;
         cur_start_ff  <= '0;
         cur_end_ff    <= '0;
         start_addr_ff <= '0;
         cur_loc_ff    <= '0;
         pen_ff        <= '0;
         cur_vis_ff    <= 1'b0;
      end else if (step_en) begin
         index_ff      <= index_in;
         h_total_ff    <= h_total_in;
         h_disp_ff     <= h_disp_in;
         h_sync_pos_ff <= h_sync_pos_in;
         h_sync_w_ff   <= h_sync_w_in;
         v_sync_w_ff   <= v_sync_w_in;
         v_total_ff    <= v_total_in;
         v_adjust_ff   <= v_adjust_in;
         v_disp_ff     <= v_disp_in;
         v_sync_pos_ff <= v_sync_pos_in;
         max_scan_ff   <= max_scan_in;
         cur_start_ff  <= cur_start_in;
         cur_end_ff    <= cur_end_in;
         start_addr_ff <= start_addr_in;
         cur_loc_ff    <= cur_loc_in;
         pen_ff        <= pen_in;
         cur_vis_ff    <= cur_vis_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/crt_controller_register_file.sv
// ----------------------------------------------------------------------------
// crt_controller_register_file
// CRT controller indexed register file with stream request/response channels.
//
// Usage:
//   req_* carries one bus access per transfer (action, byte). Every request
//   produces exactly one response on rsp_*, in order: read byte, resize and
//   illegal-index flags, and the cursor/start-address state after the access.
//   csr_wr_en writes variant_mode (sync-width packing); write only while idle.
// Timing:
//   Request is registered, decoded against the register bank and captured in
//   the response register, which drives rsp_tvalid and rsp_tdata.
//   One transfer per cycle is sustained while rsp_tready stays high; the bank
//   updates as each request moves into the response register.
// Reset:
//   All bank registers and variant_mode clear to zero, both channels empty.
// Backpressure:
//   While rsp_tready is low the response holds, the input stage still takes
//   one more request, then req_tready drops until the response drains.
// ----------------------------------------------------------------------------
`default_nettype none

module crt_controller_register_file (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] action, [9:2] bus_data, [15:10] zero
   input  wire logic [crtc_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] read_data, [8] resize_request, [9] illegal_index,
   // [10] cursor_enabled, [15:11] cursor_first_line, [20:16] cursor_last_line,
   // [36:21] display_start_out, [52:37] cursor_address_out, [55:53] zero
   output logic [crtc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import crtc_pkg::*;

   logic        variant_ff;
   logic        in_valid_ff;
   action_type  in_action_ff;
   logic [7:0]  in_data_ff;
   logic        out_valid_ff;
   rsp_type     out_ff;
   rsp_type     result;
   logic        advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   crtc_reg_bank u_bank (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .action       (in_action_ff),
      .bus_data     (in_data_ff),
      .variant_mode (variant_ff),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff   <= 1'b0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            variant_ff <= csr_wr_data;
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_action_ff <= action_type'(req_tdata[1:0]);
         in_data_ff   <= req_tdata[9:2];
      end
      if (advance) begin
         out_ff <= result;
      end
   end

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the CRT controller register file. A shadow copy of
// the register bank predicts every response. The tests are: directed corner
// accesses, sync-width packing in both variants, a long response stall, and
// random index/data access sequences with and without random idling on both channels.
// ----------------------------------------------------------------------------

module tb;
   import crtc_pkg::*;

   localparam int CYCLE_LIMIT = 100000;

   typedef struct packed {
      logic [7:0]  index;
      logic [7:0]  h_total;
      logic [7:0]  h_displayed;
      logic [7:0]  h_sync_pos;
      logic [3:0]  h_sync_w;
      logic [4:0]  v_sync_w;
      logic [7:0]  v_total;
      logic [7:0]  v_adjust;
      logic [7:0]  v_displayed;
      logic [7:0]  v_sync_pos;
      logic [4:0]  max_scan;
      logic [5:0]  cur_start;
      logic [4:0]  cur_end;
      logic [15:0] start_addr;
      logic [15:0] cursor_addr;
      logic [13:0] pen;
      logic        cur_visible;
   } crtc_bank_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   crtc_bank_type bank;
   logic       variant_shadow;
   rsp_type    rsp_expected[$];
   rsp_type    rsp_want;
   rsp_type    rsp_got;
   int         failures = 0;
   int         cycle_count = 0;
   bit         req_idle = 1'b1;
   bit         rsp_idle = 1'b1;
   int         rsp_hold_len = 0;
   int         rsp_gap = 0;

   crt_controller_register_file dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[crt_controller_register_file] ERROR");
         $finish;
      end
   end

   // Updates the shadow bank for one access and returns the response it causes.
   function automatic rsp_type bank_access(action_type act, logic [7:0] v);
      rsp_type r;
      r = '0;
      case (act)
         ACT_WRITE_INDEX: bank.index = v;
         ACT_READ_INDEX:  r.read_data = bank.index;
         ACT_WRITE_DATA: begin
            case (bank.index)
               IDX_H_TOTAL: begin
                  r.resize_request = bank.h_total != v;
                  bank.h_total = v;
               end
               IDX_H_DISPLAYED: begin
                  r.resize_request = bank.h_displayed != v;
                  bank.h_displayed = v;
               end
               IDX_H_SYNC_POS: bank.h_sync_pos = v;
               IDX_SYNC_WIDTH: begin
                  bank.v_sync_w = variant_shadow ? {1'b0, v[7:4]} : V_SYNC_FIXED;
                  bank.h_sync_w = v[3:0];
               end
               IDX_V_TOTAL: begin
                  r.resize_request = bank.v_total != v;
                  bank.v_total = v;
               end
               IDX_V_ADJUST: begin
                  r.resize_request = bank.v_adjust != v;
                  bank.v_adjust = v;
               end
               IDX_V_DISPLAYED: begin
                  r.resize_request = bank.v_displayed != v;
                  bank.v_displayed = v;
               end
               IDX_V_SYNC_POS: bank.v_sync_pos = v;
               IDX_MAX_SCAN: begin
                  r.resize_request = bank.max_scan != v[4:0];
                  bank.max_scan = v[4:0];
               end
               IDX_CURSOR_START: begin
                  bank.cur_start = v[5:0];
                  bank.cur_visible = v[6:5] != CURSOR_OFF_CODE;
               end
               IDX_CURSOR_END: bank.cur_end = v[4:0];
               IDX_START_HI:   bank.start_addr[15:8] = v;
               IDX_START_LO:   bank.start_addr[7:0] = v;
               IDX_CURSOR_HI:  bank.cursor_addr[15:8] = v;
               IDX_CURSOR_LO:  bank.cursor_addr[7:0] = v;
               IDX_PEN_HI:     bank.pen[13:8] = v[5:0];
               IDX_PEN_LO:     bank.pen[7:0] = v;
               default:        r.illegal_index = 1'b1;
            endcase
         end
         ACT_READ_DATA: begin
            case (bank.index)
               IDX_H_TOTAL:      r.read_data = bank.h_total;
               IDX_H_DISPLAYED:  r.read_data = bank.h_displayed;
               IDX_H_SYNC_POS:   r.read_data = bank.h_sync_pos;
               IDX_SYNC_WIDTH:   r.read_data = variant_shadow ?
                                    {bank.v_sync_w[3:0], bank.h_sync_w} :
                                    {4'h0, bank.h_sync_w};
               IDX_V_TOTAL:      r.read_data = bank.v_total;
               IDX_V_ADJUST:     r.read_data = bank.v_adjust;
               IDX_V_DISPLAYED:  r.read_data = bank.v_displayed;
               IDX_V_SYNC_POS:   r.read_data = bank.v_sync_pos;
               IDX_MAX_SCAN:     r.read_data = {3'b000, bank.max_scan};
               IDX_CURSOR_START: r.read_data = {2'b00, bank.cur_start};
               IDX_CURSOR_END:   r.read_data = {3'b000, bank.cur_end};
               IDX_START_HI:     r.read_data = bank.start_addr[15:8];
               IDX_START_LO:     r.read_data = bank.start_addr[7:0];
               IDX_CURSOR_HI:    r.read_data = bank.cursor_addr[15:8];
               IDX_CURSOR_LO:    r.read_data = bank.cursor_addr[7:0];
               IDX_PEN_HI:       r.read_data = {2'b00, bank.pen[13:8]};
               IDX_PEN_LO:       r.read_data = bank.pen[7:0];
               default: begin
                  r.read_data = BAD_INDEX_DATA;
                  r.illegal_index = 1'b1;
               end
            endcase
         end
      endcase
      r.cursor_enabled     = bank.cur_visible;
      r.cursor_first_line  = bank.cur_start[4:0];
      r.cursor_last_line   = bank.cur_end;
      r.display_start_out  = bank.start_addr;
      r.cursor_address_out = bank.cursor_addr;
      return r;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
         failures++;
      end
   endfunction

   // Response side: random stall after each transfer while rsp_idle is set, plus long hold-offs on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_hold_len > 0) begin
            rsp_gap = rsp_hold_len;
            rsp_hold_len = 0;
         end else if (rsp_tvalid && rsp_tready) begin
            rsp_gap = rsp_idle ? $urandom_range(0, 5) : 0;
         end
         if (rsp_gap > 0) begin
            rsp_tready <= 1'b0;
            rsp_gap = rsp_gap - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_got = rsp_type'(rsp_tdata);
         if (rsp_expected.size() == 0) begin
            $display("%0t unexpected response: expected none, actual %h", $time, rsp_tdata);
            failures++;
         end else begin
            rsp_want = rsp_expected.pop_front();
            check_field("read_data", rsp_want.read_data, rsp_got.read_data);
            check_field("resize_request", rsp_want.resize_request, rsp_got.resize_request);
            check_field("illegal_index", rsp_want.illegal_index, rsp_got.illegal_index);
            check_field("cursor_enabled", rsp_want.cursor_enabled, rsp_got.cursor_enabled);
            check_field("cursor_first_line", rsp_want.cursor_first_line,
                        rsp_got.cursor_first_line);
            check_field("cursor_last_line", rsp_want.cursor_last_line,
                        rsp_got.cursor_last_line);
            check_field("display_start_out", rsp_want.display_start_out,
                        rsp_got.display_start_out);
            check_field("cursor_address_out", rsp_want.cursor_address_out,
                        rsp_got.cursor_address_out);
         end
      end
   end

   // Called right after a rising edge; returns at the edge of the transfer.
   task automatic send_access(action_type act, logic [7:0] v);
      int gap;
      gap = req_idle ? $urandom_range(0, 5) : 0;
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b000000, v, act};
      do @(posedge clock); while (!req_tready);
      rsp_expected.push_back(bank_access(act, v));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_variant(logic mode);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      variant_shadow = mode;
   endtask

   task automatic test_directed();
      send_access(ACT_READ_INDEX, 8'hFF);
      send_access(ACT_READ_DATA, 8'h00);
      send_access(ACT_WRITE_DATA, 8'hFF);
      send_access(ACT_WRITE_DATA, 8'hFF);
      send_access(ACT_READ_DATA, 8'h00);
      send_access(ACT_WRITE_INDEX, IDX_SYNC_WIDTH);
      send_access(ACT_WRITE_DATA, 8'hA5);
      send_access(ACT_READ_DATA, 8'hFF);
      send_access(ACT_WRITE_INDEX, IDX_CURSOR_START);
      send_access(ACT_WRITE_DATA, 8'h3F);
      send_access(ACT_WRITE_DATA, 8'hFF);
      send_access(ACT_READ_DATA, 8'h00);
      send_access(ACT_WRITE_INDEX, 8'h08);
      send_access(ACT_WRITE_DATA, 8'h55);
      send_access(ACT_READ_DATA, 8'h00);
      send_access(ACT_WRITE_INDEX, 8'hFF);
      send_access(ACT_READ_INDEX, 8'h00);
      send_access(ACT_READ_DATA, 8'h00);
      send_access(ACT_WRITE_INDEX, 8'h12);
      send_access(ACT_WRITE_DATA, 8'h00);
      send_access(ACT_WRITE_INDEX, IDX_PEN_HI);
      send_access(ACT_WRITE_DATA, 8'hFF);
      send_access(ACT_READ_DATA, 8'h00);
      send_access(ACT_WRITE_INDEX, IDX_MAX_SCAN);
      send_access(ACT_WRITE_DATA, 8'hE0);
   endtask

   task automatic test_sync_packing();
      send_access(ACT_WRITE_INDEX, IDX_SYNC_WIDTH);
      send_access(ACT_WRITE_DATA, 8'h7C);
      set_variant(1'b1);
      send_access(ACT_READ_DATA, 8'h00);
      send_access(ACT_WRITE_DATA, 8'hA5);
      send_access(ACT_READ_DATA, 8'h00);
      send_access(ACT_WRITE_DATA, 8'hF0);
      send_access(ACT_READ_DATA, 8'h00);
      set_variant(1'b0);
      send_access(ACT_READ_DATA, 8'h00);
   endtask

   task automatic test_rsp_stall();
      req_idle = 1'b0;
      rsp_hold_len = 80;
      repeat (16) send_access(action_type'($urandom_range(0, 3)), 8'($urandom));
      wait_drained();
      req_idle = 1'b1;
   endtask

   // Mostly index write followed by a few data accesses, with some noise.
   task automatic test_random(int quota);
      int sent;
      int burst;
      logic [7:0] idx;
      logic [7:0] last_byte;
      sent = 0;
      last_byte = 8'h00;
      while (sent < quota) begin
         if ($urandom_range(0, 9) == 0) begin
            send_access(action_type'($urandom_range(0, 3)), 8'($urandom));
            sent++;
         end else begin
            idx = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, IDX_PEN_LO));
            send_access(ACT_WRITE_INDEX, idx);
            sent++;
            burst = $urandom_range(1, 4);
            repeat (burst) begin
               if ($urandom_range(0, 3) != 0) last_byte = 8'($urandom);
               send_access($urandom_range(0, 1) ? ACT_WRITE_DATA : ACT_READ_DATA, last_byte);
               sent++;
            end
            if ($urandom_range(0, 3) == 0) begin
               send_access(ACT_READ_INDEX, 8'($urandom));
               sent++;
            end
         end
      end
   endtask

   initial begin
      bank = '0;
      variant_shadow = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_sync_packing();
      test_rsp_stall();
      test_random(110);
      set_variant(1'b1);
      test_random(110);
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      test_random(60);
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      set_variant(1'b0);
      test_random(110);

      wait_drained();
      repeat (5) @(posedge clock);
      if (failures == 0) begin
         $display("[crt_controller_register_file] OK");
      end else begin
         $display("[crt_controller_register_file] ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/crtc_pkg.sv
rtl/crtc_reg_bank.sv
rtl/crt_controller_register_file.sv
tb/tb.sv
